>>> sv/bounded_array_insert_delete_core_assert.svh
// assertion macros for the bounded array insert/delete core
`ifndef BOUNDED_ARRAY_INSERT_DELETE_CORE_ASSERT_SVH
`define BOUNDED_ARRAY_INSERT_DELETE_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define BAI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bai assertion failed");
// next-cycle implication, disabled during reset
`define BAI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bai assertion failed");
`else
`define BAI_ASSERT_IMP(label, clk, rst, ante, cons)
`define BAI_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/bai_pkg.sv
// shared types and constants for the bounded array insert/delete core
package bai_pkg;

  localparam int REQ_W     = 3;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 6;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 7;
  localparam int DEPTH_DEF = 64;
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND  = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_UPDATE  = 3'd2,
    REQ_DELETE  = 3'd3,
    REQ_FILL    = 3'd4,
    REQ_DISPLAY = 3'd5
  } req_code_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_EMPTY  = 2'd2
  } stat_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FINAL,
    ST_FILL,
    ST_DISP_RD,
    ST_DISP_EMIT
  } state_t;

endpackage

>>> sv/bai_if.sv
// request and result channel interfaces

interface bai_req_if import bai_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source(output valid, req_type, value, position, input ready);
  modport sink(input valid, req_type, value, position, output ready);
endinterface

interface bai_res_if import bai_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [POS_W-1:0]        slot;
  logic signed [VAL_W-1:0] element;
  logic [CNT_W-1:0]        count;
  logic                    last;

  modport source(output valid, status, slot, element, count, last, input ready);
  modport sink(input valid, status, slot, element, count, last, output ready);
endinterface

>>> sv/bounded_array_insert_delete_core.sv
// Ordered array of signed 32-bit words with a count, kept in a single-port-write,
// registered-read memory and edited by a small sequencer that moves one word at
// a time. Append, update-at and any rejected request load their result on
// acceptance. Insert-at moves each word from the end down to the position up one
// slot, then writes the new word; delete-at moves each word above the position
// down one slot (none if the last element is removed). Fill writes every usable
// slot in turn; display streams the elements in order, reading each only once
// the result register is free. Each moved word is read in one state and written
// in the next. A new request is taken only when the previous one is finished and
// its result has left the output register. Capacity above DEPTH saturates at
// DEPTH; writing a capacity below the count cuts the count. The memory needs no
// clearing pass after reset: no request reads a slot at or above the count.
`include "bounded_array_insert_delete_core_assert.svh"

module bounded_array_insert_delete_core import bai_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  bai_req_if.sink          req,
  bai_res_if.source        res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  state_t              state, state_next;
  logic [CNT_W-1:0]    held, held_next;
  logic [CNT_W-1:0]    cap_reg;
  logic [CNT_W-1:0]    ucap;
  logic [CNT_W-1:0]    wcap;
  logic [CNT_W-1:0]    idx, idx_next;
  logic [CNT_W-1:0]    nbr;
  req_code_t           op;
  logic [VAL_W-1:0]    val_q;
  logic [CNT_W-1:0]    pos_q;
  logic [CNT_W-1:0]    pos_in;
  logic                take;

  // result register
  logic                res_valid, res_valid_next;
  stat_t               res_status, res_status_next;
  logic [POS_W-1:0]    res_slot, res_slot_next;
  logic [VAL_W-1:0]    res_element, res_element_next;
  logic [CNT_W-1:0]    res_count, res_count_next;
  logic                res_last, res_last_next;

  // memory
  logic [VAL_W-1:0]    mem [DEPTH];
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [VAL_W-1:0]    mem_wdata, rdata;

  // emit helper
  logic                emit;
  stat_t               e_stat;
  logic [POS_W-1:0]    e_slot;
  logic [VAL_W-1:0]    e_elem;
  logic [CNT_W-1:0]    e_cnt;
  logic                e_last;

  assign ucap   = (cap_reg > DEPTH_C) ? DEPTH_C : cap_reg;
  assign wcap   = (cfg_wdata > DEPTH_C) ? DEPTH_C : cfg_wdata;
  assign pos_in = {1'b0, req.position};
  assign take   = req.valid && req.ready;

  // shared step unit: neighbor slot, down for insert, up for delete
  assign nbr = (op == REQ_INSERT) ? (idx - CNT_W'(1)) : (idx + CNT_W'(1));

  // sequencer next state and outputs
  always_comb begin
    state_next       = state;
    held_next        = held;
    idx_next         = idx;
    mem_we           = 1'b0;
    mem_waddr        = idx[AW-1:0];
    mem_wdata        = val_q;
    mem_re           = 1'b0;
    mem_raddr        = idx[AW-1:0];
    req.ready        = 1'b0;
    emit             = 1'b0;
    e_stat           = STAT_DONE;
    e_slot           = '0;
    e_elem           = '0;
    e_cnt            = held;
    e_last           = 1'b1;
    res_valid_next   = res_valid && !res.ready;
    res_status_next  = res_status;
    res_slot_next    = res_slot;
    res_element_next = res_element;
    res_count_next   = res_count;
    res_last_next    = res_last;

    unique case (state)
      ST_IDLE: begin
        req.ready = !res_valid;
        if (req.valid && !res_valid) begin
          case (req.req_type)
            REQ_APPEND: begin
              emit = 1'b1;
              if (held >= ucap) begin
                e_stat = STAT_REJECT;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = held[AW-1:0];
                mem_wdata = req.value;
                held_next = held + CNT_W'(1);
                e_slot    = held[POS_W-1:0];
                e_cnt     = held + CNT_W'(1);
              end
            end
            REQ_INSERT: begin
              if (held >= ucap || pos_in > held) begin
                emit   = 1'b1;
                e_stat = STAT_REJECT;
              end else if (pos_in == held) begin
                emit      = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = pos_in[AW-1:0];
                mem_wdata = req.value;
                held_next = held + CNT_W'(1);
                e_slot    = req.position;
                e_cnt     = held + CNT_W'(1);
              end else begin
                idx_next   = held;
                state_next = ST_SHIFT_RD;
              end
            end
            REQ_UPDATE: begin
              emit = 1'b1;
              if (pos_in >= ucap) begin
                e_stat = STAT_REJECT;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_in[AW-1:0];
                mem_wdata = req.value;
                e_slot    = req.position;
              end
            end
            REQ_DELETE: begin
              if (pos_in >= held) begin
                emit   = 1'b1;
                e_stat = STAT_REJECT;
              end else if (pos_in + CNT_W'(1) == held) begin
                emit      = 1'b1;
                held_next = held - CNT_W'(1);
                e_slot    = req.position;
                e_cnt     = held - CNT_W'(1);
              end else begin
                idx_next   = pos_in;
                state_next = ST_SHIFT_RD;
              end
            end
            REQ_FILL: begin
              if (ucap == '0) begin
                emit  = 1'b1;
                e_cnt = '0;
              end else begin
                idx_next   = '0;
                state_next = ST_FILL;
              end
            end
            REQ_DISPLAY: begin
              if (held == '0) begin
                emit   = 1'b1;
                e_stat = STAT_EMPTY;
                e_cnt  = '0;
              end else begin
                idx_next   = '0;
                state_next = ST_DISP_RD;
              end
            end
            default: begin
              emit   = 1'b1;
              e_stat = STAT_REJECT;
            end
          endcase
        end
      end
      // read the neighbor word
      ST_SHIFT_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = nbr[AW-1:0];
        state_next = ST_SHIFT_WR;
      end
      // move it into the current slot
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata;
        idx_next  = nbr;
        if (op == REQ_INSERT) begin
          state_next = (nbr == pos_q) ? ST_FINAL : ST_SHIFT_RD;
        end else begin
          state_next = (nbr + CNT_W'(1) == held) ? ST_FINAL : ST_SHIFT_RD;
        end
      end
      // finish insert or delete
      ST_FINAL: begin
        emit       = 1'b1;
        e_slot     = pos_q[POS_W-1:0];
        state_next = ST_IDLE;
        if (op == REQ_INSERT) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[AW-1:0];
          held_next = held + CNT_W'(1);
          e_cnt     = held + CNT_W'(1);
        end else begin
          held_next = held - CNT_W'(1);
          e_cnt     = held - CNT_W'(1);
        end
      end
      // one slot per cycle
      ST_FILL: begin
        mem_we   = 1'b1;
        idx_next = idx + CNT_W'(1);
        if (idx + CNT_W'(1) == ucap) begin
          held_next  = ucap;
          emit       = 1'b1;
          e_cnt      = ucap;
          state_next = ST_IDLE;
        end
      end
      // read next element once the result register frees up
      ST_DISP_RD: begin
        if (!res_valid || res.ready) begin
          mem_re     = 1'b1;
          state_next = ST_DISP_EMIT;
        end
      end
      ST_DISP_EMIT: begin
        emit   = 1'b1;
        e_slot = idx[POS_W-1:0];
        e_elem = rdata;
        e_last = (idx + CNT_W'(1) == held);
        if (idx + CNT_W'(1) == held) begin
          state_next = ST_IDLE;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = ST_DISP_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (emit) begin
      res_valid_next   = 1'b1;
      res_status_next  = e_stat;
      res_slot_next    = e_slot;
      res_element_next = e_elem;
      res_count_next   = e_cnt;
      res_last_next    = e_last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      held      <= '0;
      cap_reg   <= CAP_RESET;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      if (cfg_we) begin
        cap_reg <= cfg_wdata;
        held    <= (held > wcap) ? wcap : held_next;
      end else begin
        held <= held_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    res_status  <= res_status_next;
    res_slot    <= res_slot_next;
    res_element <= res_element_next;
    res_count   <= res_count_next;
    res_last    <= res_last_next;
    if (take) begin
      op    <= req_code_t'(req.req_type);
      val_q <= req.value;
      pos_q <= pos_in;
    end
  end

  // element memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  assign res.valid   = res_valid;
  assign res.status  = res_status;
  assign res.slot    = res_slot;
  assign res.element = res_element;
  assign res.count   = res_count;
  assign res.last    = res_last;

  // checks
  `BAI_ASSERT_IMP(a_held_cap, clk, rst, 1'b1, held <= ucap)
  `BAI_ASSERT_IMP(a_fill_range, clk, rst, state == ST_FILL, idx < ucap)
  `BAI_ASSERT_IMP(a_shift_range, clk, rst, state == ST_SHIFT_RD || state == ST_SHIFT_WR, idx < DEPTH_C)
  `BAI_ASSERT_NXT(a_disp_free, clk, rst, state == ST_DISP_RD && mem_re, !res_valid)

endmodule

>>> sim/tb.sv
// testbench for the bounded array insert/delete core: scoreboard class, drivers, top module
`timescale 1ns / 1ps

import bai_pkg::*;

// one result transaction as seen on the result channel
typedef struct packed {
  logic [STAT_W-1:0]       status;
  logic [POS_W-1:0]        slot;
  logic signed [VAL_W-1:0] element;
  logic [CNT_W-1:0]        count;
  logic                    last;
} array_result_t;

// mirrors the array contents and queues the results each request should produce
class array_scoreboard;
  logic signed [VAL_W-1:0] cells [DEPTH_DEF];
  int unsigned             held;
  logic [CNT_W-1:0]        capacity;
  array_result_t           expected_q [$];
  int unsigned             errors;

  function new();
    held     = 0;
    capacity = CAP_RESET;
    errors   = 0;
  endfunction

  // usable slots, saturating at the array depth
  function int unsigned room();
    return (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // a smaller capacity trims the element count
  function void set_capacity(logic [CNT_W-1:0] cap);
    capacity = cap;
    if (held > room())
      held = room();
  endfunction

  function void push_result(stat_t status, int unsigned slot, logic signed [VAL_W-1:0] element,
                            logic last);
    array_result_t r;
    r.status  = status;
    r.slot    = POS_W'(slot);
    r.element = element;
    r.count   = CNT_W'(held);
    r.last    = last;
    expected_q.push_back(r);
  endfunction

  // apply one accepted request to the mirror and queue its results
  function void note_request(logic [REQ_W-1:0] kind, logic signed [VAL_W-1:0] word,
                             logic [POS_W-1:0] where);
    int unsigned lim;
    int unsigned pos;
    lim = room();
    pos = where;
    case (kind)
      REQ_APPEND: begin
        if (held >= lim) begin
          push_result(STAT_REJECT, 0, '0, 1'b1);
        end else begin
          cells[held] = word;
          held++;
          push_result(STAT_DONE, held - 1, '0, 1'b1);
        end
      end
      REQ_INSERT: begin
        if (held >= lim || pos > held) begin
          push_result(STAT_REJECT, 0, '0, 1'b1);
        end else begin
          for (int i = held; i > pos; i--)
            cells[i] = cells[i-1];
          cells[pos] = word;
          held++;
          push_result(STAT_DONE, pos, '0, 1'b1);
        end
      end
      REQ_UPDATE: begin
        if (pos >= lim) begin
          push_result(STAT_REJECT, 0, '0, 1'b1);
        end else begin
          cells[pos] = word;
          push_result(STAT_DONE, pos, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (pos >= held) begin
          push_result(STAT_REJECT, 0, '0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < held; i++)
            cells[i] = cells[i+1];
          held--;
          push_result(STAT_DONE, pos, '0, 1'b1);
        end
      end
      REQ_FILL: begin
        for (int i = 0; i < lim; i++)
          cells[i] = word;
        held = lim;
        push_result(STAT_DONE, 0, '0, 1'b1);
      end
      REQ_DISPLAY: begin
        if (held == 0) begin
          push_result(STAT_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < held; i++)
            push_result(STAT_DONE, i, cells[i], (i + 1 == held));
        end
      end
      default: push_result(STAT_REJECT, 0, '0, 1'b1);
    endcase
  endfunction

  // compare one result transaction with the oldest expectation
  function void check_result(array_result_t got);
    array_result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result: status %0d slot %0d element %0d count %0d last %0d",
             got.status, got.slot, got.element, got.count, got.last);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.slot !== want.slot) begin
      $error("slot: expected %0d, got %0d", want.slot, got.slot);
      errors++;
    end
    if (got.element !== want.element) begin
      $error("element: expected %0d, got %0d", want.element, got.element);
      errors++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int unsigned CYCLE_LIMIT    = 800_000;
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 40;

  // request codes the block does not know
  localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

  localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh8000_0000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             idle_on;
  logic             squeeze_req;
  int unsigned      cycle_count;

  bai_req_if req_if ();
  bai_res_if res_if ();

  array_scoreboard sb = new();

  bounded_array_insert_delete_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .res       (res_if)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // known values on every input from time zero
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    idle_on         = 1'b1;
    squeeze_req     = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_APPEND;
    req_if.value    = '0;
    req_if.position = '0;
    res_if.ready    = 1'b0;
  end

  // watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  // result side: check each accepted transaction, stall at random
  initial begin : result_sink
    array_result_t got;
    int unsigned   stall_left;
    bit            squeezed;
    stall_left = 0;
    squeezed   = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got.status  = res_if.status;
        got.slot    = res_if.slot;
        got.element = res_if.element;
        got.count   = res_if.count;
        got.last    = res_if.last;
        sb.check_result(got);
      end
      // one long hold-off so the core backs up into the request side
      if (squeeze_req && !squeezed) begin
        squeezed   = 1'b1;
        stall_left = SQUEEZE_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // offer one request and wait until it is taken
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic signed [VAL_W-1:0] word,
                              input logic [POS_W-1:0] where);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.value    <= word;
    req_if.position <= where;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(kind, word, where);
  endtask

  // drain all results, let the core settle, then write the capacity
  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    sb.set_capacity(cap);
    cfg_we <= 1'b0;
  endtask

  // random word with extra weight on the corners
  function automatic logic signed [VAL_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // mostly in-range edits on the current contents, some out-of-range noise
  task automatic random_item();
    int unsigned      roll;
    int unsigned      h;
    int unsigned      lim;
    int unsigned      top;
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] where;
    h     = sb.held;
    lim   = sb.room();
    roll  = $urandom_range(0, 99);
    where = POS_W'($urandom_range(0, 63));
    if (roll < 22) begin
      kind = REQ_APPEND;
    end else if (roll < 42) begin
      kind = REQ_INSERT;
      top  = (h > 63) ? 63 : h;
      if ($urandom_range(0, 9) != 0)
        where = POS_W'($urandom_range(0, top));
    end else if (roll < 56) begin
      kind = REQ_UPDATE;
      if (lim > 0 && $urandom_range(0, 9) != 0)
        where = POS_W'($urandom_range(0, lim - 1));
    end else if (roll < 80) begin
      kind = REQ_DELETE;
      if (h > 0 && $urandom_range(0, 9) != 0)
        where = POS_W'($urandom_range(0, h - 1));
    end else if (roll < 84) begin
      kind = REQ_FILL;
    end else if (roll < 96) begin
      kind = REQ_DISPLAY;
    end else begin
      kind = (roll % 2 == 0) ? REQ_RSVD_A : REQ_RSVD_B;
    end
    send_request(kind, rand_word(), where);
  endtask

  task automatic random_phase(input logic [CNT_W-1:0] cap, input int unsigned n_items);
    set_capacity(cap);
    repeat (n_items) random_item();
  endtask

  // stimulus
  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty array corners, shifting edits, full array
    send_request(REQ_DISPLAY, 32'sd0, 6'd0);
    send_request(REQ_DELETE, 32'sd0, 6'd0);
    send_request(REQ_INSERT, 32'sd11, 6'd1);
    send_request(REQ_INSERT, 32'sd12, 6'd0);
    send_request(REQ_APPEND, WORD_MAX, 6'd0);
    send_request(REQ_APPEND, WORD_MIN, 6'd0);
    send_request(REQ_INSERT, -32'sd7, 6'd1);
    send_request(REQ_INSERT, 32'sd99, 6'd4);
    send_request(REQ_UPDATE, 32'sh1234_5678, 6'd63);
    send_request(REQ_UPDATE, 32'sd42, 6'd2);
    send_request(REQ_DELETE, 32'sd0, 6'd4);
    send_request(REQ_DELETE, 32'sd0, 6'd0);
    send_request(REQ_DISPLAY, 32'sd0, 6'd0);
    send_request(REQ_RSVD_A, 32'sd1, 6'd0);
    send_request(REQ_RSVD_B, 32'sd1, 6'd63);
    send_request(REQ_FILL, 32'sh5A5A_A5A5, 6'd0);
    send_request(REQ_APPEND, 32'sd3, 6'd0);
    send_request(REQ_INSERT, 32'sd3, 6'd10);
    send_request(REQ_DELETE, 32'sd0, 6'd63);
    send_request(REQ_INSERT, -32'sd1, 6'd63);
    send_request(REQ_UPDATE, WORD_MIN, 6'd63);
    send_request(REQ_DISPLAY, 32'sd0, 6'd0);

    // shrinking the capacity trims the count
    set_capacity(7'd9);
    send_request(REQ_DISPLAY, 32'sd0, 6'd0);

    // zero capacity: fill leaves the array empty, display reports empty, update rejects
    set_capacity(7'd0);
    send_request(REQ_FILL, 32'sd5, 6'd0);
    send_request(REQ_DISPLAY, 32'sd0, 6'd0);
    send_request(REQ_UPDATE, 32'sd5, 6'd0);

    // capacity beyond the depth saturates
    set_capacity(7'd127);
    send_request(REQ_FILL, -32'sd2, 6'd0);
    send_request(REQ_APPEND, 32'sd6, 6'd0);

    // random phases over several capacities, first one with the long hold-off
    set_capacity(7'd0);
    squeeze_req <= 1'b1;
    random_phase(7'd64, 130);
    random_phase(7'd100, 50);
    random_phase(7'd1, 30);
    random_phase(7'd20, 80);
    random_phase(7'd0, 15);
    idle_on <= 1'b0;
    random_phase(7'd64, 75);

    // wait out the remaining results, then watch for strays
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
